### rtl/core/float_hypot3_top_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef FLOAT_HYPOT3_TOP_MACROS_SVH
`define FLOAT_HYPOT3_TOP_MACROS_SVH

// Consequent checked after the antecedent, delayed by the argument n.
`define FH3_ASSERT_DELAYED(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("fh3 delayed check failed");

// Invariant checked at every edge outside reset.
`define FH3_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fh3 invariant check failed");

`endif

### rtl/core/fh3_pkg.sv
package fh3_pkg;

   localparam logic [31:0] FP_INF    = 32'h7F80_0000;
   localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
   localparam logic [7:0]  EXP_MAX   = 8'hFF;

   localparam int SQ_LAT     = 4;
   localparam int ADD_LAT    = 4;
   localparam int SQRT_STEPS = 25;
   localparam int SQRT_LAT   = SQRT_STEPS + 2;
   localparam int CORE_LAT   = SQ_LAT + 2 * ADD_LAT + SQRT_LAT;
   localparam int TOTAL_LAT  = CORE_LAT + 1;

   // Operand handed to the rounding stages: value is t * 2^(eb - 127 - 47),
   // t has its leading one at bit 47 whenever eb is at least 1.
   typedef struct packed {
      logic               valid;
      logic               inf;
      logic signed [9:0]  eb;
      logic [47:0]        t;
   } rnd_op_type;

   typedef struct packed {
      logic [23:0]        sig;
      logic signed [9:0]  exb;
   } norm_type;

   // Subnormals are brought to a leading one at bit 23 with a lowered exponent.
   function automatic norm_type normalise(input logic [7:0] e, input logic [22:0] m);
      norm_type   r;
      logic [4:0] p;
      logic [4:0] lz;
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (m[i]) p = 5'(i);
      end
      lz = 5'd23 - p;
      if (e == 8'd0) begin
         r.sig = {1'b0, m} << lz;
         r.exb = 10'sd1 - $signed({5'd0, lz});
      end else begin
         r.sig = {1'b1, m};
         r.exb = $signed({2'd0, e});
      end
      return r;
   endfunction

endpackage

### rtl/core/float_hypot3_top.sv
// Binary32 vector length sqrt(x*x + y*y + z*z), each operation rounded to nearest even.
// One item per clock; the path from start to the rsp_valid strobe runs through
// 4 squaring + 4 + 4 adding + 27 square-root stages (one root bit per step stage) + output.
// Reset is synchronous and clears all valid flags; busy is high only during reset.
// Results are strobed for one cycle and cannot be held off by the receiver.
module float_hypot3_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_x_bits,
   input  logic [31:0] req_y_bits,
   input  logic [31:0] req_z_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_magnitude_bits
);

   localparam int NLAT = fh3_pkg::CORE_LAT;
   localparam int ALAT = fh3_pkg::ADD_LAT;

   logic        accept;
   logic        x_nan, y_nan, z_nan;
   logic        nan_in;
   logic [31:0] nan_bits_in;

   logic        sq_valid;
   logic [31:0] xx, yy, zz;
   logic        s1_valid, s2_valid, rt_valid;
   logic [31:0] s1, s2, rt;

   logic [31:0] zz_ff       [0:ALAT-1];
   logic        nan_ff      [0:NLAT-1];
   logic [31:0] nan_bits_ff [0:NLAT-1];

   logic        rsp_valid_ff;
   logic [31:0] magnitude_ff, magnitude_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // the first NaN in operand order comes through, quietened
   always_comb begin
      x_nan       = (req_x_bits[30:23] == fh3_pkg::EXP_MAX) && (req_x_bits[22:0] != 23'd0);
      y_nan       = (req_y_bits[30:23] == fh3_pkg::EXP_MAX) && (req_y_bits[22:0] != 23'd0);
      z_nan       = (req_z_bits[30:23] == fh3_pkg::EXP_MAX) && (req_z_bits[22:0] != 23'd0);
      nan_in      = x_nan || y_nan || z_nan;
      nan_bits_in = (x_nan ? req_x_bits : (y_nan ? req_y_bits : req_z_bits))
                    | fh3_pkg::QUIET_BIT;
   end

   fh3_square u_sq_x (
      .clock (clock), .reset (reset), .in_valid (accept), .a (req_x_bits),
      .out_valid (sq_valid), .result (xx)
   );

   fh3_square u_sq_y (
      .clock (clock), .reset (reset), .in_valid (accept), .a (req_y_bits),
      .out_valid (), .result (yy)
   );

   fh3_square u_sq_z (
      .clock (clock), .reset (reset), .in_valid (accept), .a (req_z_bits),
      .out_valid (), .result (zz)
   );

   fh3_add u_add_xy (
      .clock (clock), .reset (reset), .in_valid (sq_valid), .a (xx), .b (yy),
      .out_valid (s1_valid), .result (s1)
   );

   fh3_add u_add_z (
      .clock (clock), .reset (reset), .in_valid (s1_valid), .a (s1), .b (zz_ff[ALAT-1]),
      .out_valid (s2_valid), .result (s2)
   );

   fh3_sqrt u_sqrt (
      .clock (clock), .reset (reset), .in_valid (s2_valid), .a (s2),
      .out_valid (rt_valid), .result (rt)
   );

   // z*z waits for the first add
   always_ff @(posedge clock) begin
      zz_ff[0] <= zz;
      for (int k = 1; k < ALAT; k++) begin
         zz_ff[k] <= zz_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      nan_ff[0]      <= nan_in;
      nan_bits_ff[0] <= nan_bits_in;
      for (int k = 1; k < NLAT; k++) begin
         nan_ff[k]      <= nan_ff[k - 1];
         nan_bits_ff[k] <= nan_bits_ff[k - 1];
      end
   end

   assign magnitude_in = nan_ff[NLAT-1] ? nan_bits_ff[NLAT-1] : rt;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      magnitude_ff <= magnitude_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_magnitude_bits = magnitude_ff;

endmodule

### rtl/core/fh3_round.sv
module fh3_round (
   input  logic                clock,
   input  logic                reset,
   input  fh3_pkg::rnd_op_type op,
   output logic                out_valid,
   output logic [31:0]         result
);

   logic        valid1_ff;
   logic        ovf_ff, ovf_in;
   logic [7:0]  exp_ff, exp_in;
   logic [23:0] mant_ff, mant_in;
   logic        sticky_ff, sticky_in;
   logic        valid2_ff;
   logic [31:0] result_ff, result_in;

   logic [47:0] d;
   logic [47:0] lost;
   logic [9:0]  sh;
   logic        up;
   logic [30:0] packed_sum;

   // stage 1: overflow check, denormalising shift when the exponent is below range
   always_comb begin
      d      = op.t;
      lost   = '0;
      sh     = 10'd0;
      exp_in = op.eb[7:0];
      ovf_in = op.inf || ($signed(op.eb) > 10'sd254);
      if ($signed(op.eb) < 10'sd1) begin
         sh     = 10'd1 - $unsigned(op.eb);
         exp_in = 8'd0;
         if (sh > 10'd48) begin
            d    = '0;
            lost = op.t;
         end else begin
            d    = op.t >> sh[5:0];
            lost = op.t & ~({48{1'b1}} << sh[5:0]);
         end
      end
      mant_in   = d[46:23];
      sticky_in = (|d[22:0]) || (|lost);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= op.valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff    <= ovf_in;
      exp_ff    <= exp_in;
      mant_ff   <= mant_in;
      sticky_ff <= sticky_in;
      result_ff <= result_in;
   end

   // stage 2: nearest-even; a carry out of the fraction bumps the exponent
   always_comb begin
      up         = mant_ff[0] & (sticky_ff | mant_ff[1]);
      packed_sum = {exp_ff, mant_ff[23:1]} + 31'(up);
      result_in  = ovf_ff ? fh3_pkg::FP_INF : {1'b0, packed_sum};
   end

   assign out_valid = valid2_ff;
   assign result    = result_ff;

endmodule

### rtl/core/fh3_square.sv
module fh3_square (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] a,
   output logic        out_valid,
   output logic [31:0] result
);

   fh3_pkg::norm_type nrm;

   logic               valid1_ff;
   logic [23:0]        sig_ff;
   logic signed [9:0]  exb1_ff;
   logic               inf1_ff, inf_in;
   logic               zero1_ff, zero_in;

   logic               valid2_ff;
   logic [47:0]        prod_ff, prod_in;
   logic signed [9:0]  exb2_ff;
   logic               inf2_ff;
   logic               zero2_ff;

   fh3_pkg::rnd_op_type op;

   always_comb begin
      nrm     = fh3_pkg::normalise(a[30:23], a[22:0]);
      inf_in  = (a[30:23] == fh3_pkg::EXP_MAX);
      zero_in = (a[30:0] == 31'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign prod_in = sig_ff * sig_ff;

   always_ff @(posedge clock) begin
      sig_ff   <= nrm.sig;
      exb1_ff  <= nrm.exb;
      inf1_ff  <= inf_in;
      zero1_ff <= zero_in;
      prod_ff  <= prod_in;
      exb2_ff  <= exb1_ff;
      inf2_ff  <= inf1_ff;
      zero2_ff <= zero1_ff;
   end

   // product of two normalised significands needs at most a one-bit shift
   always_comb begin
      op.valid = valid2_ff;
      op.inf   = inf2_ff;
      if (zero2_ff) begin
         op.t  = '0;
         op.eb = '0;
      end else begin
         op.t  = prod_ff[47] ? prod_ff : {prod_ff[46:0], 1'b0};
         op.eb = (exb2_ff <<< 1) - 10'sd127 + $signed({9'd0, prod_ff[47]});
      end
   end

   fh3_round u_round (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .out_valid (out_valid),
      .result    (result)
   );

endmodule

### rtl/core/fh3_add.sv
// Adds two non-negative binary32 values (or +inf).
module fh3_add (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        out_valid,
   output logic [31:0] result
);

   logic [30:0] hi, lo;
   logic [7:0]  ehi, elo;

   logic        valid1_ff;
   logic        inf1_ff, inf_in;
   logic [23:0] siga_ff, siga_in;
   logic [23:0] sigb_ff, sigb_in;
   logic [7:0]  ea_ff, ea_in;
   logic [7:0]  d_ff, d_in;

   logic        valid2_ff;
   logic        inf2_ff;
   logic [47:0] t_ff, t_in;
   logic [9:0]  eb_ff, eb_in;

   logic [26:0] bx;
   logic [26:0] al;
   logic        st;
   logic [27:0] s;

   fh3_pkg::rnd_op_type op;

   // stage 1: order by magnitude, exponent difference
   always_comb begin
      if (a[30:0] >= b[30:0]) begin
         hi = a[30:0];
         lo = b[30:0];
      end else begin
         hi = b[30:0];
         lo = a[30:0];
      end
      inf_in  = (a[30:23] == fh3_pkg::EXP_MAX) || (b[30:23] == fh3_pkg::EXP_MAX);
      ehi     = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
      elo     = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
      siga_in = {hi[30:23] != 8'd0, hi[22:0]};
      sigb_in = {lo[30:23] != 8'd0, lo[22:0]};
      ea_in   = ehi;
      d_in    = ehi - elo;
   end

   // stage 2: align with guard, round and sticky bits, add, place leading one
   always_comb begin
      bx = {sigb_ff, 3'b000};
      if (d_ff >= 8'd27) begin
         al = '0;
         st = |sigb_ff;
      end else begin
         al = bx >> d_ff[4:0];
         st = |(bx & ~({27{1'b1}} << d_ff[4:0]));
      end
      s = {1'b0, siga_ff, 3'b000} + {1'b0, al[26:1], al[0] | st};
      if (s[27]) begin
         t_in  = {s, 20'd0};
         eb_in = {2'd0, ea_ff} + 10'd1;
      end else if (s[26]) begin
         t_in  = {s[26:0], 21'd0};
         eb_in = {2'd0, ea_ff};
      end else begin
         // both subnormal: exact, leave it to the denormalising path
         t_in  = {s[25:0], 22'd0};
         eb_in = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      inf1_ff <= inf_in;
      siga_ff <= siga_in;
      sigb_ff <= sigb_in;
      ea_ff   <= ea_in;
      d_ff    <= d_in;
      inf2_ff <= inf1_ff;
      t_ff    <= t_in;
      eb_ff   <= eb_in;
   end

   always_comb begin
      op.valid = valid2_ff;
      op.inf   = inf2_ff;
      op.eb    = $signed(eb_ff);
      op.t     = t_ff;
   end

   fh3_round u_round (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .out_valid (out_valid),
      .result    (result)
   );

endmodule

### rtl/core/fh3_sqrt.sv
// Square root of a non-negative binary32, one root bit per step stage.
module fh3_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] a,
   output logic        out_valid,
   output logic [31:0] result
);

   localparam int NSTEP = fh3_pkg::SQRT_STEPS;

   fh3_pkg::norm_type nrm;
   logic signed [9:0] ex;
   logic signed [9:0] half;
   logic signed [9:0] eout;
   logic              odd;
   logic [24:0]       m_in;
   logic [7:0]        e_in;
   logic              inf_in, zero_in;

   logic        valid_ff [0:NSTEP];
   logic [24:0] m_ff     [0:NSTEP];
   logic [7:0]  e_ff     [0:NSTEP];
   logic        inf_ff   [0:NSTEP];
   logic        zero_ff  [0:NSTEP];
   logic [25:0] rem_ff   [0:NSTEP];
   logic [24:0] root_ff  [0:NSTEP];

   logic        valid_out_ff;
   logic [31:0] result_ff, result_in;
   logic [24:0] r;
   logic        up;
   logic [30:0] packed_sum;

   // make the exponent even, halve it
   always_comb begin
      nrm     = fh3_pkg::normalise(a[30:23], a[22:0]);
      inf_in  = (a[30:23] == fh3_pkg::EXP_MAX);
      zero_in = (a[30:0] == 31'd0);
      ex      = nrm.exb - 10'sd127;
      odd     = ex[0];
      m_in    = odd ? {nrm.sig, 1'b0} : {1'b0, nrm.sig};
      half    = (ex - $signed({9'd0, odd})) >>> 1;
      eout    = half + 10'sd127;
      e_in    = eout[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      m_ff[0]    <= m_in;
      e_ff[0]    <= e_in;
      inf_ff[0]  <= inf_in;
      zero_ff[0] <= zero_in;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic [49:0] big;
      logic [27:0] rem_n;
      logic [27:0] trial;
      logic [27:0] diff;
      logic        ge;
      logic [25:0] rem_in;
      logic [24:0] root_in;

      // radicand is the significand followed by 25 zero bits
      always_comb begin
         big     = {m_ff[i], 25'd0};
         rem_n   = {rem_ff[i], big[49 - 2 * i -: 2]};
         trial   = {1'b0, root_ff[i], 2'b01};
         diff    = rem_n - trial;
         ge      = (rem_n >= trial);
         rem_in  = ge ? diff[25:0] : rem_n[25:0];
         root_in = {root_ff[i][23:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i + 1] <= 1'b0;
         end else begin
            valid_ff[i + 1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         m_ff[i + 1]    <= m_ff[i];
         e_ff[i + 1]    <= e_ff[i];
         inf_ff[i + 1]  <= inf_ff[i];
         zero_ff[i + 1] <= zero_ff[i];
         rem_ff[i + 1]  <= rem_in;
         root_ff[i + 1] <= root_in;
      end
   end

   // root carries one bit below the result lsb; the remainder is sticky
   always_comb begin
      r          = root_ff[NSTEP];
      up         = r[0] & ((rem_ff[NSTEP] != 26'd0) | r[1]);
      packed_sum = {e_ff[NSTEP], r[23:1]} + 31'(up);
      if (inf_ff[NSTEP]) begin
         result_in = fh3_pkg::FP_INF;
      end else if (zero_ff[NSTEP]) begin
         result_in = 32'd0;
      end else begin
         result_in = {1'b0, packed_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else begin
         valid_out_ff <= valid_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid = valid_out_ff;
   assign result    = result_ff;

endmodule

### rtl/core/fh3_checker.sv
`include "float_hypot3_top_macros.svh"

module fh3_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_x_bits,
   input logic [31:0] req_y_bits,
   input logic [31:0] req_z_bits,
   input logic        rsp_valid,
   input logic [31:0] rsp_magnitude_bits
);

   localparam int LAT = fh3_pkg::TOTAL_LAT;

   logic        accept;
   logic        x_nan;
   logic        all_zero;
   logic [31:0] x_quiet;
   logic        neg_number;

   assign accept     = start && !busy;
   assign x_nan      = (req_x_bits[30:23] == fh3_pkg::EXP_MAX) && (req_x_bits[22:0] != 23'd0);
   assign x_quiet    = req_x_bits | fh3_pkg::QUIET_BIT;
   assign all_zero   = (req_x_bits[30:0] == 31'd0) && (req_y_bits[30:0] == 31'd0)
                       && (req_z_bits[30:0] == 31'd0);
   assign neg_number = rsp_magnitude_bits[31]
                       && (rsp_magnitude_bits[30:23] != fh3_pkg::EXP_MAX);

   // every accepted item is strobed out on rsp_valid
   `FH3_ASSERT_DELAYED(a_item_out, clock, reset, accept, LAT, rsp_valid)

   // a NaN in x wins and comes out quietened
   `FH3_ASSERT_DELAYED(a_nan_x, clock, reset, accept && x_nan, LAT, rsp_magnitude_bits == $past(x_quiet, LAT))

   // zeros of either sign give +0
   `FH3_ASSERT_DELAYED(a_zero, clock, reset, accept && all_zero, LAT, rsp_magnitude_bits == 32'd0)

   // a length is never negative unless it is a NaN
   `FH3_ASSERT_ALWAYS(a_sign, clock, reset, !(rsp_valid && neg_number))

endmodule

bind float_hypot3_top fh3_checker u_fh3_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_x_bits         (req_x_bits),
   .req_y_bits         (req_y_bits),
   .req_z_bits         (req_z_bits),
   .rsp_valid          (rsp_valid),
   .rsp_magnitude_bits (rsp_magnitude_bits)
);
